FILE: hw/rtl/qs_pkg.sv
package qs_pkg;

	typedef struct packed {
		logic [31:0] key_value;
		logic        is_final;
	} qs_in_t;

	typedef struct packed {
		logic [31:0] sorted_value;
		logic        is_final_res;
		logic        overflowed;
	} qs_out_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_POP,
		ST_POP_WAIT,
		ST_PIV_RD,
		ST_PIV_WAIT,
		ST_SCAN_I,
		ST_SCAN_J,
		ST_SWAP,
		ST_PUSH_HI,
		ST_PUSH_LO,
		ST_OUT_RD,
		ST_OUT_WAIT
	} qs_state_t;

	localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

endpackage

FILE: hw/rtl/qs_stream_if.sv
interface qs_stream_if #(
	parameter int WIDTH = 34
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/qs_front.sv
// Front part: registers incoming items into a two-entry queue.
module qs_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  qs_pkg::qs_in_t in_item,
	output logic           q_valid,
	input  logic           q_pop,
	output qs_pkg::qs_in_t q_item
);
	import qs_pkg::*;

	qs_in_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];

	// hold items in arrival order
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

FILE: hw/rtl/qs_back.sv
// Back part: stores keys, sorts with an explicit range stack, streams results.
module qs_back #(
	parameter int MAX_KEYS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_pop,
	input  qs_pkg::qs_in_t  q_item,
	output logic            out_valid,
	input  logic            out_ready,
	output qs_pkg::qs_out_t out_item
);
	import qs_pkg::*;

	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int SD = MAX_KEYS + 2;
	localparam int SW = $clog2(SD + 1);
	localparam int PW = $clog2(SD);

	logic [31:0]   mem_q [MAX_KEYS];
	logic [2*AW-1:0] stk_q [SD];

	qs_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [SW-1:0] sp_q;
	logic [AW-1:0] lo_q, hi_q;
	logic [AW:0]   i_q, j_q;
	logic [31:0]   piv_q, rd_q, vi_q;
	logic [AW-1:0] k_q;
	logic          out_v_q;
	qs_out_t       out_q;
	logic [2*AW-1:0] pop_q;

	// memory port controls
	logic          we;
	logic [AW-1:0] wa, ra;
	logic [31:0]   wd;
	logic [AW:0]   mid;
	logic          accept, do_push;
	logic          out_last;

	assign mid      = {1'b0, lo_q} + (({1'b0, hi_q} - {1'b0, lo_q}) >> 1);
	assign accept   = q_valid && state_q == ST_LOAD;
	assign q_pop    = accept;
	assign do_push  = accept && cnt_q != CW'(MAX_KEYS);
	assign out_last = (CW'(k_q) + CW'(1) == cnt_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && q_item.is_final) begin
					if ((do_push ? cnt_q + CW'(1) : cnt_q) > CW'(1))
						state_d = ST_POP;
					else if ((do_push ? cnt_q + CW'(1) : cnt_q) == CW'(1))
						state_d = ST_OUT_RD;
				end
			end
			ST_POP:      state_d = (sp_q == '0) ? ST_OUT_RD : ST_POP_WAIT;
			ST_POP_WAIT: state_d = ST_PIV_RD;
			ST_PIV_RD:   state_d = ST_PIV_WAIT;
			ST_PIV_WAIT: state_d = ST_SCAN_I;
			ST_SCAN_I: begin
				if (i_q > j_q) state_d = ST_PUSH_HI;
				else if (!(i_q < {1'b0, hi_q} && rd_q < piv_q)) state_d = ST_SCAN_J;
			end
			ST_SCAN_J: begin
				if (!(j_q > {1'b0, lo_q} && rd_q > piv_q))
					state_d = (i_q <= j_q) ? ST_SWAP : ST_PUSH_HI;
			end
			// leave once the indexes cross, before j can wrap below zero
			ST_SWAP:    state_d = (i_q + 2'd2 <= j_q) ? ST_SCAN_I : ST_PUSH_HI;
			ST_PUSH_HI: state_d = ST_PUSH_LO;
			ST_PUSH_LO: state_d = ST_POP;
			ST_OUT_RD:  state_d = (!out_v_q || out_ready) ? ST_OUT_WAIT : ST_OUT_RD;
			ST_OUT_WAIT: state_d = out_last ? ST_LOAD : ST_OUT_RD;
			default:    state_d = ST_LOAD;
		endcase
	end

	// memory address selection
	always_comb begin
		we = 1'b0;
		wa = cnt_q[AW-1:0];
		wd = q_item.key_value ^ SIGN_FLIP;
		ra = i_q[AW-1:0];
		unique case (state_q)
			ST_LOAD: we = do_push;
			ST_PIV_RD: ra = mid[AW-1:0];
			ST_SCAN_I: begin
				ra = i_q[AW-1:0];
				if (i_q <= j_q && !(i_q < {1'b0, hi_q} && rd_q < piv_q))
					ra = j_q[AW-1:0];
				else if (i_q <= j_q)
					ra = AW'(i_q + 1'b1);
			end
			ST_SCAN_J: begin
				ra = AW'(j_q - 1'b1);
				if (!(j_q > {1'b0, lo_q} && rd_q > piv_q)) begin
					we = (i_q <= j_q);
					wa = i_q[AW-1:0];
					wd = rd_q;
				end
			end
			ST_SWAP: begin
				we = 1'b1;
				wa = j_q[AW-1:0];
				wd = vi_q;
				ra = AW'(i_q + 1'b1);
			end
			ST_OUT_RD: ra = k_q;
			default: ;
		endcase
	end

	// key store
	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rd_q <= mem_q[ra];
	end

	// sort datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_POP_WAIT: begin
				lo_q <= pop_q[2*AW-1:AW];
				hi_q <= pop_q[AW-1:0];
				i_q  <= {1'b0, pop_q[2*AW-1:AW]};
				j_q  <= {1'b0, pop_q[AW-1:0]};
			end
			ST_PIV_WAIT: piv_q <= rd_q;
			ST_SCAN_I: begin
				if (i_q <= j_q && i_q < {1'b0, hi_q} && rd_q < piv_q) i_q <= i_q + 1'b1;
				else vi_q <= rd_q;
			end
			ST_SCAN_J: begin
				if (j_q > {1'b0, lo_q} && rd_q > piv_q) j_q <= j_q - 1'b1;
			end
			ST_SWAP: begin
				i_q <= i_q + 1'b1;
				j_q <= j_q - 1'b1;
			end
			default: ;
		endcase
	end

	// range stack, read through a register at the top entry
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD)
			stk_q[0] <= {AW'(0), AW'(cnt_q - CW'(1) + CW'(do_push))};
		else if (state_q == ST_PUSH_HI && i_q < {1'b0, hi_q})
			stk_q[PW'(sp_q)] <= {i_q[AW-1:0], hi_q};
		else if (state_q == ST_PUSH_LO && {1'b0, lo_q} + 1'b1 < i_q)
			stk_q[PW'(sp_q)] <= {lo_q, AW'(i_q - 1'b1)};
		pop_q <= stk_q[PW'(sp_q - SW'(1))];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			sp_q    <= '0;
			k_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT_WAIT) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					k_q <= '0;
					if (accept) begin
						if (do_push) cnt_q <= cnt_q + CW'(1);
						else ovf_q <= 1'b1;
						if (q_item.is_final) sp_q <= SW'(1);
					end
				end
				ST_POP: if (sp_q != '0) sp_q <= sp_q - SW'(1);
				ST_PUSH_HI: if (i_q < {1'b0, hi_q}) sp_q <= sp_q + SW'(1);
				ST_PUSH_LO: if ({1'b0, lo_q} + 1'b1 < i_q) sp_q <= sp_q + SW'(1);
				ST_OUT_WAIT: begin
					out_q.sorted_value <= rd_q ^ SIGN_FLIP;
					out_q.overflowed   <= ovf_q;
					if (out_last) begin
						out_q.is_final_res <= 1'b1;
						cnt_q <= '0;
						ovf_q <= 1'b0;
						sp_q  <= '0;
					end else begin
						out_q.is_final_res <= 1'b0;
						k_q <= k_q + AW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_v_q;
	assign out_item  = out_q;
endmodule

FILE: hw/rtl/quicksort_engine_top.sv
// Batch key sorter.
// Input channel (in): key_value plus is_final; one item per key, the item
// with is_final set closes the batch and starts the sort.
// Output channel (out): sorted_value ascending, is_final_res on the last
// key, overflowed on every result of a batch that lost keys past MAX_KEYS.
// Keys load back to back while no batch sorts or drains; each key passes
// through a two-entry front queue before it is written to the store.
// The sort walks the key store through its single read port; each index
// range taken from the stack goes through pop, pivot read, the i and j
// scans with their swaps, and a push of each part still left to sort.
// Each result is then read from the store before the next one starts.
// Input stalls once the front queue fills while a batch sorts or drains.
// Reset clears counters, stack pointer and state; no store clearing pass.
// A stalled receiver holds the output register and pauses the drain.
module quicksort_engine_top #(
	parameter int MAX_KEYS = 64
) (
	input logic       clk,
	input logic       arst_n,
	qs_stream_if.sink   in,
	qs_stream_if.source out
);
	import qs_pkg::*;

	qs_in_t  in_item, q_item;
	qs_out_t out_item;
	logic    q_valid, q_pop;

	assign in_item  = qs_in_t'(in.data);
	assign out.data = out_item;

	qs_front u_front (
		.clk, .arst_n,
		.in_valid(in.valid), .in_ready(in.ready), .in_item,
		.q_valid, .q_pop, .q_item
	);

	qs_back #(.MAX_KEYS(MAX_KEYS)) u_back (
		.clk, .arst_n,
		.q_valid, .q_pop, .q_item,
		.out_valid(out.valid), .out_ready(out.ready), .out_item
	);
endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import qs_pkg::*;

	localparam int CAPACITY = 64;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;

	qs_stream_if #(.WIDTH(33)) in_ch ();
	qs_stream_if #(.WIDTH(34)) out_ch ();

	quicksort_engine_top #(.MAX_KEYS(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch.sink),
		.out(out_ch.source)
	);

	// pending input items and expected sorted keys
	qs_in_t key_queue[$];
	qs_out_t sorted_queue[$];

	// predictor copy of the batch
	logic signed [31:0] batch_keys[$];
	bit batch_lost;
	int errors;
	bit quiet;
	bit in_fired;
	int gap_left;
	int stall_left;
	int idle_cycles;

	// build expectations for one accepted item
	task automatic predict_item(input qs_in_t it);
		logic signed [31:0] tmp;
		if (batch_keys.size() < CAPACITY)
			batch_keys.push_back($signed(it.key_value));
		else
			batch_lost = 1'b1;
		if (it.is_final) begin
			for (int a = 1; a < batch_keys.size(); a++) begin
				tmp = batch_keys[a];
				for (int b = a - 1; b >= 0 && batch_keys[b] > tmp; b--) begin
					batch_keys[b + 1] = batch_keys[b];
					batch_keys[b] = tmp;
				end
			end
			for (int k = 0; k < batch_keys.size(); k++)
				sorted_queue.push_back('{batch_keys[k], k == batch_keys.size() - 1, batch_lost});
			batch_keys.delete();
			batch_lost = 1'b0;
		end
	endtask

	task automatic add_batch(input int n, input int mode);
		logic [31:0] v;
		for (int k = 0; k < n; k++) begin
			case (mode)
				0: v = $urandom;
				1: v = $urandom_range(7) - 3;
				2: v = 32'd5;
				3: v = k;
				4: v = n - k;
				default: v = (k % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
			endcase
			key_queue.push_back('{v, k == n - 1});
		end
	endtask

	always #5 clk = ~clk;

	// drive inputs at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (in_ch.valid && !in_fired) begin
			// hold item
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			in_ch.valid <= 1'b0;
		end else if (key_queue.size() > 0 && !quiet && $urandom_range(9) == 0) begin
			gap_left <= $urandom_range(14, 1) - 1;
			in_ch.valid <= 1'b0;
		end else if (key_queue.size() > 0) begin
			in_ch.data <= key_queue.pop_front();
			in_ch.valid <= 1'b1;
		end else begin
			in_ch.valid <= 1'b0;
		end
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(7) == 0) begin
			stall_left <= $urandom_range(14, 1) - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// sample handshakes at the rising edge
	always @(posedge clk) begin
		qs_out_t got;
		qs_out_t want;
		in_fired <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (in_ch.valid && in_ch.ready)
				predict_item(in_ch.data);
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (sorted_queue.size() == 0) begin
					errors++;
					$display("%0t: unexpected key: expected none, actual %0d/%b/%b", $time,
						$signed(got.sorted_value), got.is_final_res, got.overflowed);
				end else begin
					want = sorted_queue.pop_front();
					if (got.sorted_value !== want.sorted_value) begin
						errors++;
						$display("%0t: sorted_value expected %0d, actual %0d", $time,
							$signed(want.sorted_value), $signed(got.sorted_value));
					end
					if (got.is_final_res !== want.is_final_res) begin
						errors++;
						$display("%0t: is_final_res expected %b, actual %b", $time,
							want.is_final_res, got.is_final_res);
					end
					if (got.overflowed !== want.overflowed) begin
						errors++;
						$display("%0t: overflowed expected %b, actual %b", $time,
							want.overflowed, got.overflowed);
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("quicksort_engine_top verification failed");
				$finish;
			end
		end
	end

	initial begin
		int n;
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		errors = 0;
		quiet = 0;
		in_fired = 0;
		gap_left = 0;
		stall_left = 0;
		idle_cycles = 0;
		batch_lost = 0;

		// directed: single key, extremes, duplicates, ordered, full and overflowing
		key_queue.push_back('{32'h8000_0000, 1'b1});
		key_queue.push_back('{32'h7fff_ffff, 1'b1});
		add_batch(2, 5);
		add_batch(4, 2);
		add_batch(5, 3);
		add_batch(5, 4);
		add_batch(3, 0);
		add_batch(CAPACITY, 1);
		add_batch(CAPACITY + 3, 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// random batches, mostly small
		while (key_queue.size() < 215) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(CAPACITY + 4, 40) : $urandom_range(12, 1);
			add_batch(n, $urandom_range(5));
		end

		// drop idling for the last part of the run
		while (key_queue.size() > 40)
			@(posedge clk);
		quiet = 1;

		while (key_queue.size() > 0 || in_ch.valid || sorted_queue.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && sorted_queue.size() == 0 && batch_keys.size() == 0)
			$display("quicksort_engine_top verification clean");
		else
			$display("quicksort_engine_top verification failed");
		$finish;
	end
endmodule

FILE: filelist.f
hw/rtl/qs_pkg.sv
hw/rtl/qs_stream_if.sv
hw/rtl/qs_front.sv
hw/rtl/qs_back.sv
hw/rtl/quicksort_engine_top.sv
sim/tb.sv
